/* rtl/mcg_pkg.sv */
`timescale 1ns / 1ps
// mcg_pkg: shared constants, codes and stage sideband types of the mask coverage generator
// no dependencies; used by every other file in rtl

package mcg_pkg;

	// frame and field sizes
	localparam int MAX_SIDE   = 4096;
	localparam int COORD_W    = 12;
	localparam int COV_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// config register widths
	localparam int LEN_W    = 17;
	localparam int CENTRE_W = 18;
	localparam int DIR_W    = 16;
	localparam logic signed [DIR_W-1:0] DIR_Y_RESET = 16'sd16384;

	// datapath widths
	localparam int DELTA_W = 19;
	localparam int PROD_W  = 35;
	localparam int SQR_W   = 36;
	localparam int ALONG_W = 36;
	localparam int D2_W    = 37;
	localparam int RR_W    = 34;
	localparam int NUM_W   = 38;

	// square root pipeline: one root bit per stage
	localparam int SQ_IN_W   = 54;
	localparam int SQ_ROOT_W = 27;
	localparam int SQ_REM_W  = 29;
	localparam int SQ_STAGES = SQ_ROOT_W;

	// divider pipeline: one quotient bit per stage
	localparam int DIV_W      = 32;
	localparam int TQ_FRAC    = 16;
	localparam int DIV_STAGES = TQ_FRAC;
	localparam int TQ_W       = TQ_FRAC + 1;

	// smoothstep polynomial
	localparam logic [TQ_W:0] SMOOTH_THREE = 18'd196608;
	localparam int SQ_TQ_W = 2 * TQ_W;
	localparam int POLY_W  = SQ_TQ_W + TQ_W + 1;
	localparam int SCALED_W = POLY_W + COV_W;
	localparam int ROUND_SHIFT = 48;

	// total register stages from input transfer to result register
	localparam int PIPE_DEPTH = 3 + SQ_STAGES + 1 + DIV_STAGES + 4;
	localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE     = 3'd0,
		REG_INVERT   = 3'd1,
		REG_FEATHER  = 3'd2,
		REG_RADIUS   = 3'd3,
		REG_CENTRE_X = 3'd4,
		REG_CENTRE_Y = 3'd5,
		REG_DIR_X    = 3'd6,
		REG_DIR_Y    = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_OPEN   = 2'd0,
		MODE_LINEAR = 2'd1,
		MODE_RADIAL = 2'd2,
		MODE_RASTER = 2'd3
	} mode_t;

	// carried alongside the square root
	typedef struct packed {
		logic signed [ALONG_W-1:0] along;
		logic                      hard;
		logic [COV_W-1:0]          raster;
	} sq_side_t;

	// carried alongside the divider and the polynomial
	typedef struct packed {
		logic             hard;
		logic [COV_W-1:0] raster;
		logic             tq_zero;
		logic             tq_full;
	} div_side_t;

endpackage

/* rtl/mcg_if.sv */
`timescale 1ns / 1ps
// mcg_pixel_if and mcg_result_if: valid/ready channels of the mask coverage generator
// depends on mcg_pkg

interface mcg_pixel_if;
	import mcg_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [COV_W-1:0]   raster_coverage;

	modport source (output valid, pixel_x, pixel_y, raster_coverage, input ready);
	modport sink (input valid, pixel_x, pixel_y, raster_coverage, output ready);
endinterface

interface mcg_result_if;
	import mcg_pkg::*;
	logic             valid;
	logic             ready;
	logic [COV_W-1:0] coverage;

	modport source (output valid, coverage, input ready);
	modport sink (input valid, coverage, output ready);
endinterface

/* rtl/mcg_sqrt.sv */
`timescale 1ns / 1ps
// mcg_sqrt: pipelined integer square root, one root bit per stage, with a sideband
// depends on mcg_pkg

module mcg_sqrt import mcg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [SQ_IN_W-1:0]   radicand,
	input  sq_side_t             in_side,
	output logic                 out_valid,
	output logic [SQ_ROOT_W-1:0] root,
	output sq_side_t             out_side
);

	logic                 v_s     [SQ_STAGES];
	logic [SQ_REM_W-1:0]  rem_s   [SQ_STAGES];
	logic [SQ_ROOT_W-1:0] root_s  [SQ_STAGES];
	logic [SQ_IN_W-1:0]   rest_s  [SQ_STAGES];
	sq_side_t             side_s  [SQ_STAGES];

	logic [SQ_REM_W-1:0]  rem_d   [SQ_STAGES];
	logic [SQ_ROOT_W-1:0] root_d  [SQ_STAGES];
	logic [SQ_IN_W-1:0]   rest_d  [SQ_STAGES];
	sq_side_t             side_d  [SQ_STAGES];

	// each stage brings down two radicand bits and tries one root bit
	always_comb begin
		logic [SQ_REM_W-1:0]  rem_in;
		logic [SQ_REM_W-1:0]  remx;
		logic [SQ_REM_W-1:0]  trial;
		logic [SQ_ROOT_W-1:0] root_in;
		logic [SQ_IN_W-1:0]   rest_in;
		for (int k = 0; k < SQ_STAGES; k++) begin
			if (k == 0) begin
				rem_in    = '0;
				root_in   = '0;
				rest_in   = radicand;
				side_d[k] = in_side;
			end else begin
				rem_in    = rem_s[k-1];
				root_in   = root_s[k-1];
				rest_in   = rest_s[k-1];
				side_d[k] = side_s[k-1];
			end
			remx      = {rem_in[SQ_REM_W-3:0], rest_in[SQ_IN_W-1 -: 2]};
			trial     = {root_in, 2'b01};
			rest_d[k] = {rest_in[SQ_IN_W-3:0], 2'b00};
			if (remx >= trial) begin
				rem_d[k]  = remx - trial;
				root_d[k] = {root_in[SQ_ROOT_W-2:0], 1'b1};
			end else begin
				rem_d[k]  = remx;
				root_d[k] = {root_in[SQ_ROOT_W-2:0], 1'b0};
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SQ_STAGES; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < SQ_STAGES; k++) v_s[k] <= v_s[k-1];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQ_STAGES; k++) begin
				rem_s[k]  <= rem_d[k];
				root_s[k] <= root_d[k];
				rest_s[k] <= rest_d[k];
				side_s[k] <= side_d[k];
			end
		end
	end

	assign out_valid = v_s[SQ_STAGES-1];
	assign root      = root_s[SQ_STAGES-1];
	assign out_side  = side_s[SQ_STAGES-1];

endmodule

/* rtl/mcg_div.sv */
`timescale 1ns / 1ps
// mcg_div: pipelined restoring divider giving the fraction num/den (num < den), Q0.16
// depends on mcg_pkg

module mcg_div import mcg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [DIV_W-1:0]   num,
	input  logic [DIV_W-1:0]   den,
	input  div_side_t          in_side,
	output logic               out_valid,
	output logic [TQ_FRAC-1:0] quo,
	output div_side_t          out_side
);

	logic               v_s    [DIV_STAGES];
	logic [DIV_W-1:0]   rem_s  [DIV_STAGES];
	logic [DIV_W-1:0]   den_s  [DIV_STAGES];
	logic [TQ_FRAC-1:0] quo_s  [DIV_STAGES];
	div_side_t          side_s [DIV_STAGES];

	logic [DIV_W-1:0]   rem_d  [DIV_STAGES];
	logic [DIV_W-1:0]   den_d  [DIV_STAGES];
	logic [TQ_FRAC-1:0] quo_d  [DIV_STAGES];
	div_side_t          side_d [DIV_STAGES];

	// one shift, compare and subtract per stage
	always_comb begin
		logic [DIV_W-1:0]   rem_in;
		logic [DIV_W:0]     rem2;
		logic [TQ_FRAC-1:0] quo_in;
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				rem_in    = num;
				den_d[k]  = den;
				quo_in    = '0;
				side_d[k] = in_side;
			end else begin
				rem_in    = rem_s[k-1];
				den_d[k]  = den_s[k-1];
				quo_in    = quo_s[k-1];
				side_d[k] = side_s[k-1];
			end
			rem2 = {rem_in, 1'b0};
			if (rem2 >= {1'b0, den_d[k]}) begin
				rem_d[k] = DIV_W'(rem2 - {1'b0, den_d[k]});
				quo_d[k] = {quo_in[TQ_FRAC-2:0], 1'b1};
			end else begin
				rem_d[k] = rem2[DIV_W-1:0];
				quo_d[k] = {quo_in[TQ_FRAC-2:0], 1'b0};
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < DIV_STAGES; k++) v_s[k] <= v_s[k-1];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				rem_s[k]  <= rem_d[k];
				den_s[k]  <= den_d[k];
				quo_s[k]  <= quo_d[k];
				side_s[k] <= side_d[k];
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES-1];
	assign quo       = quo_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule

/* rtl/mask_coverage_generator.sv */
`timescale 1ns / 1ps
// mask_coverage_generator: per-pixel mask coverage (open, linear, radial, raster)
// depends on mcg_pkg, mcg_if, mcg_sqrt, mcg_div
//
//   channel  | kind          | payload
//   ---------+---------------+-----------------------------------------
//   pixel    | valid/ready   | pixel_x, pixel_y, raster_coverage
//   result   | valid/ready   | coverage
//   cfg      | write only    | cfg_we, cfg_index, cfg_data
//
// one pixel per clock while no result is held at the output; 3 setup stages, 27 square root
// stages, 1 fraction setup stage, 16 divider stages and 4 polynomial/output stages.
// all modes share the same path, so results leave in order.
// a result held at the output freezes the whole pipeline; nothing is lost.
// reset clears valid bits and sets registers to their defaults (dir_y = 1.0).

module mask_coverage_generator import mcg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mcg_pixel_if.sink             pixel,
	mcg_result_if.source          result
);

	// config registers
	mode_t                       mode_q;
	logic                        invert_q;
	logic [LEN_W-1:0]            feather_q;
	logic [LEN_W-1:0]            radius_q;
	logic signed [CENTRE_W-1:0]  centre_x_q;
	logic signed [CENTRE_W-1:0]  centre_y_q;
	logic signed [DIR_W-1:0]     dir_x_q;
	logic signed [DIR_W-1:0]     dir_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_OPEN;
			invert_q   <= 1'b0;
			feather_q  <= '0;
			radius_q   <= '0;
			centre_x_q <= '0;
			centre_y_q <= '0;
			dir_x_q    <= '0;
			dir_y_q    <= DIR_Y_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MODE:     mode_q     <= mode_t'(cfg_data[1:0]);
				REG_INVERT:   invert_q   <= cfg_data[0];
				REG_FEATHER:  feather_q  <= cfg_data[LEN_W-1:0];
				REG_RADIUS:   radius_q   <= cfg_data[LEN_W-1:0];
				REG_CENTRE_X: centre_x_q <= cfg_data[CENTRE_W-1:0];
				REG_CENTRE_Y: centre_y_q <= cfg_data[CENTRE_W-1:0];
				REG_DIR_X:    dir_x_q    <= cfg_data[DIR_W-1:0];
				REG_DIR_Y:    dir_y_q    <= cfg_data[DIR_W-1:0];
				default:      ;
			endcase
		end
	end

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// the whole pipeline moves unless the result register is held
	assign en          = !v_s8 || result.ready;
	assign pixel.ready = en;

	// stage 1: clamp, pixel centre and offsets from the mask centre
	logic [COORD_W-1:0]        cx, cy;
	logic signed [DELTA_W-1:0] dx_s1, dy_s1;
	logic [COV_W-1:0]          raster_s1;

	always_comb begin
		cx = (int'(pixel.pixel_x) > MAX_SIDE - 1) ? COORD_W'(MAX_SIDE - 1) : pixel.pixel_x;
		cy = (int'(pixel.pixel_y) > MAX_SIDE - 1) ? COORD_W'(MAX_SIDE - 1) : pixel.pixel_y;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1     <= $signed({3'b000, cx, 4'b1000}) - DELTA_W'(centre_x_q);
			dy_s1     <= $signed({3'b000, cy, 4'b1000}) - DELTA_W'(centre_y_q);
			raster_s1 <= pixel.raster_coverage;
		end
	end

	// stage 2: projections and squares
	logic signed [PROD_W-1:0]  px_s2, py_s2;
	logic [SQR_W-1:0]          dx2_s2, dy2_s2;
	logic [RR_W-1:0]           rr_s2;
	logic [COV_W-1:0]          raster_s2;
	logic signed [2*DELTA_W-1:0] dxx, dyy;

	assign dxx = dx_s1 * dx_s1;
	assign dyy = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2     <= dx_s1 * dir_x_q;
			py_s2     <= dy_s1 * dir_y_q;
			dx2_s2    <= dxx[SQR_W-1:0];
			dy2_s2    <= dyy[SQR_W-1:0];
			rr_s2     <= radius_q * radius_q;
			raster_s2 <= raster_s1;
		end
	end

	// stage 3: sums and the zero-feather step
	logic signed [ALONG_W-1:0] along_c;
	logic [D2_W-1:0]           d2_c;
	logic [D2_W-1:0]           d2_s3;
	sq_side_t                  side_s3;

	assign along_c = ALONG_W'(px_s2) + ALONG_W'(py_s2);
	assign d2_c    = D2_W'(dx2_s2) + D2_W'(dy2_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3          <= d2_c;
			side_s3.along  <= along_c;
			side_s3.hard   <= (mode_q == MODE_LINEAR) ? !along_c[ALONG_W-1]
			                                          : (d2_c < D2_W'(rr_s2));
			side_s3.raster <= raster_s2;
		end
	end

	// distance in 1/4096 pixel
	logic                 sq_valid;
	logic [SQ_ROOT_W-1:0] sq_dist;
	sq_side_t             sq_side;

	mcg_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.radicand  ({1'b0, d2_s3, 16'h0000}),
		.in_side   (side_s3),
		.out_valid (sq_valid),
		.root      (sq_dist),
		.out_side  (sq_side)
	);

	// stage 4: fraction numerator/denominator and clamp flags
	logic signed [NUM_W-1:0] num_c;
	logic [DIV_W-1:0]        den_c;
	logic                    zero_c, full_c;
	logic [DIV_W-1:0]        num_s4, den_s4;
	div_side_t               side_s4;

	always_comb begin
		if (mode_q == MODE_LINEAR) begin
			num_c = {{(NUM_W-ALONG_W){sq_side.along[ALONG_W-1]}}, sq_side.along}
			      + $signed({8'h00, feather_q, 13'h0000});
			den_c = {1'b0, feather_q, 14'h0000};
		end else begin
			num_c = $signed({11'h000, sq_dist}) - $signed({13'h0000, radius_q, 8'h00});
			den_c = {7'h00, feather_q, 8'h00};
		end
		zero_c = num_c[NUM_W-1] || (num_c == '0);
		full_c = !zero_c && (num_c >= $signed({6'h00, den_c}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4          <= num_c[DIV_W-1:0];
			den_s4          <= den_c;
			side_s4.hard    <= sq_side.hard;
			side_s4.raster  <= sq_side.raster;
			side_s4.tq_zero <= zero_c;
			side_s4.tq_full <= full_c;
		end
	end

	logic               div_valid;
	logic [TQ_FRAC-1:0] quo;
	div_side_t          div_side;

	mcg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num       (num_s4),
		.den       (den_s4),
		.in_side   (side_s4),
		.out_valid (div_valid),
		.quo       (quo),
		.out_side  (div_side)
	);

	// stage 5: t squared and (3 - 2t)
	logic [TQ_W-1:0]    tq_c;
	logic [SQ_TQ_W-1:0] tsq_s5;
	logic [TQ_W:0]      w_s5;
	div_side_t          side_s5;

	always_comb begin
		if (div_side.tq_zero) tq_c = '0;
		else if (div_side.tq_full) tq_c = {1'b1, {TQ_FRAC{1'b0}}};
		else tq_c = {1'b0, quo};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tsq_s5  <= tq_c * tq_c;
			w_s5    <= SMOOTH_THREE - {tq_c, 1'b0};
			side_s5 <= div_side;
		end
	end

	// stage 6: polynomial
	logic [POLY_W-1:0] poly_s6;
	div_side_t         side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			poly_s6 <= tsq_s5 * w_s5;
			side_s6 <= side_s5;
		end
	end

	// stage 7: times 255, rounded half up
	logic [SCALED_W-1:0] scaled_c;
	logic [COV_W-1:0]    s255_s7;
	div_side_t           side_s7;

	assign scaled_c = {poly_s6, 8'h00} - {8'h00, poly_s6}
	                + (SCALED_W'(1) << (ROUND_SHIFT - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			s255_s7 <= scaled_c[ROUND_SHIFT +: COV_W];
			side_s7 <= side_s6;
		end
	end

	// stage 8: mode select, invert, result register
	logic [COV_W-1:0] cov_c, cov_s8;

	always_comb begin
		logic [COV_W-1:0] base;
		case (mode_q)
			MODE_RASTER: base = side_s7.raster;
			MODE_LINEAR: base = (feather_q == '0) ? {COV_W{side_s7.hard}} : s255_s7;
			MODE_RADIAL: base = (feather_q == '0) ? {COV_W{side_s7.hard}} : ~s255_s7;
			default:     base = '1;
		endcase
		cov_c = (invert_q && mode_q != MODE_OPEN) ? ~base : base;
	end

	always_ff @(posedge clk) begin
		if (en) cov_s8 <= cov_c;
	end

	// valid bits of the top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= pixel.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_valid;
			v_s5 <= div_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	assign result.valid    = v_s8;
	assign result.coverage = cov_s8;

endmodule

/* rtl/mcg_checker.sv */
`timescale 1ns / 1ps
// mcg_checker: port-level assertions for mask_coverage_generator, bound to the top level
// depends on mcg_pkg

module mcg_checker import mcg_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [COV_W-1:0] coverage
);

	logic             in_xfer, out_xfer;
	logic [CNT_W-1:0] cnt_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// items inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (in_xfer && !out_xfer) cnt_q <= cnt_q + 1'b1;
		else if (!in_xfer && out_xfer) cnt_q <= cnt_q - 1'b1;
	end

	// input only stalls behind a held result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a held result");

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(coverage)))
		else $error("held result changed");

	// no result without an item inside
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (cnt_q != '0))
		else $error("result transfer with no item inside");

	// occupancy never exceeds the pipeline depth
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PIPE_DEPTH))
		else $error("more items inside than pipeline stages");

endmodule

bind mask_coverage_generator mcg_checker u_mcg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.coverage  (result.coverage)
);

/* tb/sv/tb_mask_coverage_generator.sv */
`timescale 1ns / 1ps
// tb_mask_coverage_generator: self-checking bench for the mask coverage generator
// depends on mcg_pkg, mcg_if and the block rtl; predicts every coverage and compares in order

module tb_mask_coverage_generator;
	import mcg_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	mcg_pixel_if pixel ();
	mcg_result_if result ();

	mask_coverage_generator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pixel(pixel.sink), .result(result.source)
	);

	always #5 clk = ~clk;

	// shadow copy of the block registers
	mode_t              sh_mode;
	logic               sh_invert;
	logic [LEN_W-1:0]   sh_feather;
	logic [LEN_W-1:0]   sh_radius;
	logic signed [CENTRE_W-1:0] sh_cx, sh_cy;
	logic signed [DIR_W-1:0]    sh_dirx, sh_diry;

	logic [COV_W-1:0] cov_queue[$];
	int errors = 0;
	int n_sent = 0;
	int n_got = 0;
	longint cycles = 0;
	logic stall_on = 1'b0;

	typedef struct {
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [COV_W-1:0]   rb;
	} pixel_item_t;

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// 255 times smoothstep of num/den, rounded half up
	function automatic logic [COV_W-1:0] smooth_cov(longint num, longint den);
		longint unsigned tq, p, s;
		if (num < 0) num = 0;
		if (num > den) num = den;
		tq = (longint'(num) <<< 16) / den;
		p = tq * tq * (64'd196608 - 2 * tq);
		s = (255 * p + (64'd1 << 47)) >> 48;
		return s[COV_W-1:0];
	endfunction

	function automatic logic [COV_W-1:0] predict_coverage(pixel_item_t it);
		longint dx, dy, f, r, along;
		longint unsigned d2;
		logic [COV_W-1:0] cov;
		dx = longint'(it.px) * 16 + 8 - longint'(sh_cx);
		dy = longint'(it.py) * 16 + 8 - longint'(sh_cy);
		f = longint'(sh_feather);
		r = longint'(sh_radius);
		if (sh_mode == MODE_OPEN) return 8'd255;
		case (sh_mode)
			MODE_RASTER: cov = it.rb;
			MODE_LINEAR: begin
				along = dx * longint'(sh_dirx) + dy * longint'(sh_diry);
				if (f == 0) cov = (along < 0) ? 8'd0 : 8'd255;
				else cov = smooth_cov(along + f * 8192, f * 16384);
			end
			default: begin
				d2 = dx * dx + dy * dy;
				if (f == 0) cov = (d2 < r * r) ? 8'd255 : 8'd0;
				else cov = 8'd255 - smooth_cov(longint'(int_sqrt(d2 << 16)) - r * 256, f * 256);
			end
		endcase
		if (sh_invert) cov = 8'd255 - cov;
		return cov;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE:     sh_mode = mode_t'(val[1:0]);
			REG_INVERT:   sh_invert = val[0];
			REG_FEATHER:  sh_feather = val[LEN_W-1:0];
			REG_RADIUS:   sh_radius = val[LEN_W-1:0];
			REG_CENTRE_X: sh_cx = val[CENTRE_W-1:0];
			REG_CENTRE_Y: sh_cy = val[CENTRE_W-1:0];
			REG_DIR_X:    sh_dirx = val[DIR_W-1:0];
			default:      sh_diry = val[DIR_W-1:0];
		endcase
	endtask

	// send one pixel; valid stays high across a burst, lowered only on a gap
	task automatic send_pixel(pixel_item_t it, bit gap_after, int expect_cov);
		pixel.valid <= 1'b1;
		pixel.pixel_x <= it.px;
		pixel.pixel_y <= it.py;
		pixel.raster_coverage <= it.rb;
		do @(posedge clk); while (!pixel.ready);
		if (expect_cov >= 0 && expect_cov != predict_coverage(it)) begin
			$display("%0t table row mismatch: expected %0d actual %0d", $time,
				expect_cov, predict_coverage(it));
			errors++;
		end
		cov_queue.push_back(predict_coverage(it));
		n_sent++;
		if (gap_after) begin
			pixel.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		while (cov_queue.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	// result checking against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			if (cov_queue.size() == 0) begin
				$display("%0t unexpected result: expected none actual %0d", $time,
					result.coverage);
				errors++;
			end else begin
				logic [COV_W-1:0] exp_cov;
				exp_cov = cov_queue.pop_front();
				n_got++;
				if (result.coverage !== exp_cov) begin
					$display("%0t coverage mismatch: expected %0d actual %0d", $time,
						exp_cov, result.coverage);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern: long ready stretches and stall runs
	always @(posedge clk) begin
		if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
		if (stall_on) result.ready <= ($urandom_range(0, 3) == 0);
		else result.ready <= 1'b1;
	end

	// timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	typedef struct {
		pixel_item_t it;
		int          cov;
	} table_row_t;

	task automatic run_random(int count, bit edgy);
		pixel_item_t it;
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			it.px = edgy && $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 12'hFFF : 12'h0)
				: COORD_W'($urandom);
			it.py = edgy && $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 12'hFFF : 12'h0)
				: COORD_W'($urandom);
			it.rb = COV_W'($urandom);
			if (burst == 0) burst = $urandom_range(1, 30);
			burst--;
			send_pixel(it, burst == 0 && $urandom_range(0, 2) != 0, -1);
		end
		pixel.valid <= 1'b0;
		drain();
	endtask

	initial begin
		table_row_t rows[$];
		table_row_t row;
		logic signed [CENTRE_W-1:0] cx;
		logic signed [CENTRE_W-1:0] cy;
		pixel.valid = 1'b0;
		pixel.pixel_x = '0;
		pixel.pixel_y = '0;
		pixel.raster_coverage = '0;
		sh_mode = MODE_OPEN; sh_invert = 1'b0; sh_feather = '0; sh_radius = '0;
		sh_cx = '0; sh_cy = '0; sh_dirx = '0; sh_diry = DIR_Y_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: open after reset, extremes of coordinates
		rows = '{
			'{'{12'd0, 12'd0, 8'd0}, 255},
			'{'{12'hFFF, 12'hFFF, 8'hFF}, 255},
			'{'{12'h800, 12'h7FF, 8'h55}, 255}
		};
		foreach (rows[i]) send_pixel(rows[i].it, 1'b0, rows[i].cov);
		pixel.valid <= 1'b0;
		drain();

		// raster pass-through and its complement
		write_reg(REG_MODE, CFG_DATA_W'(MODE_RASTER));
		rows = '{ '{'{12'd1, 12'd2, 8'h00}, 0}, '{'{12'd3, 12'd4, 8'hFF}, 255},
			'{'{12'd5, 12'd6, 8'hA5}, 165} };
		foreach (rows[i]) send_pixel(rows[i].it, 1'b1, rows[i].cov);
		drain();
		write_reg(REG_INVERT, CFG_DATA_W'(1));
		rows = '{ '{'{12'd1, 12'd2, 8'h00}, 255}, '{'{12'd3, 12'd4, 8'h5A}, 165} };
		foreach (rows[i]) send_pixel(rows[i].it, 1'b0, rows[i].cov);
		pixel.valid <= 1'b0;
		drain();

		// linear hard step around the centre line, dir_y = 1.0
		write_reg(REG_INVERT, '0);
		write_reg(REG_MODE, CFG_DATA_W'(MODE_LINEAR));
		write_reg(REG_CENTRE_Y, 18'd1600);
		rows = '{ '{'{12'd10, 12'd99, 8'd0}, 0}, '{'{12'd10, 12'd100, 8'd0}, 255},
			'{'{12'd0, 12'hFFF, 8'd0}, 255} };
		foreach (rows[i]) send_pixel(rows[i].it, 1'b0, rows[i].cov);
		pixel.valid <= 1'b0;
		drain();
		// feathered ramp and direction beyond unit range
		write_reg(REG_FEATHER, CFG_DATA_W'(17'd320));
		for (int k = 80; k < 120; k += 5) begin
			row.it = '{12'd7, k[11:0], 8'd0};
			send_pixel(row.it, 1'b0, -1);
		end
		pixel.valid <= 1'b0;
		drain();
		write_reg(REG_DIR_X, CFG_DATA_W'(16'h8000));
		write_reg(REG_DIR_Y, CFG_DATA_W'(16'h7FFF));
		write_reg(REG_FEATHER, CFG_DATA_W'(17'h1FFFF));
		write_reg(REG_CENTRE_X, 18'h20000);
		rows = '{ '{'{12'hFFF, 12'd0, 8'd0}, -1}, '{'{12'd0, 12'hFFF, 8'd0}, -1} };
		foreach (rows[i]) send_pixel(rows[i].it, 1'b0, rows[i].cov);
		pixel.valid <= 1'b0;
		drain();

		// radial hard disc and largest radius
		write_reg(REG_MODE, CFG_DATA_W'(MODE_RADIAL));
		write_reg(REG_FEATHER, '0);
		write_reg(REG_RADIUS, CFG_DATA_W'(17'd160));
		write_reg(REG_CENTRE_X, 18'd1608);
		write_reg(REG_CENTRE_Y, 18'd1608);
		rows = '{ '{'{12'd100, 12'd100, 8'd0}, 255}, '{'{12'd110, 12'd100, 8'd0}, 0},
			'{'{12'd109, 12'd100, 8'd0}, 255} };
		foreach (rows[i]) send_pixel(rows[i].it, 1'b0, rows[i].cov);
		pixel.valid <= 1'b0;
		drain();
		write_reg(REG_RADIUS, CFG_DATA_W'(17'h1FFFF));
		write_reg(REG_CENTRE_X, 18'h1FFFF);
		write_reg(REG_CENTRE_Y, 18'h20000);
		rows = '{ '{'{12'd0, 12'd0, 8'd0}, -1}, '{'{12'hFFF, 12'hFFF, 8'd0}, -1} };
		foreach (rows[i]) send_pixel(rows[i].it, 1'b0, rows[i].cov);
		pixel.valid <= 1'b0;
		drain();

		// random phases over a spread of settings
		for (int ph = 0; ph < 15; ph++) begin
			write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 3)));
			write_reg(REG_INVERT, CFG_DATA_W'($urandom_range(0, 1)));
			case ($urandom_range(0, 3))
				0: write_reg(REG_FEATHER, '0);
				1: write_reg(REG_FEATHER, CFG_DATA_W'(17'h1FFFF));
				default: write_reg(REG_FEATHER, CFG_DATA_W'($urandom_range(1, 40000)));
			endcase
			write_reg(REG_RADIUS, CFG_DATA_W'($urandom_range(0, 3) == 0 ? 17'h1FFFF
				: $urandom_range(0, 60000)));
			cx = $urandom_range(0, 4) == 0 ? $signed(CENTRE_W'($urandom))
				: $signed(CENTRE_W'($urandom_range(0, 65535)));
			cy = $urandom_range(0, 4) == 0 ? $signed(CENTRE_W'($urandom))
				: $signed(CENTRE_W'($urandom_range(0, 65535)));
			write_reg(REG_CENTRE_X, cx);
			write_reg(REG_CENTRE_Y, cy);
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_DIR_X, CFG_DATA_W'(DIR_W'($urandom)));
				write_reg(REG_DIR_Y, CFG_DATA_W'(DIR_W'($urandom)));
			end else begin
				write_reg(REG_DIR_X,
					CFG_DATA_W'(DIR_W'($signed($urandom_range(0, 32768)) - 16384)));
				write_reg(REG_DIR_Y,
					CFG_DATA_W'(DIR_W'($signed($urandom_range(0, 32768)) - 16384)));
			end
			run_random(50, ph % 3 == 0);
		end

		$display("covered %0d pixels, %0d results checked, all four modes with and without invert",
			n_sent, n_got);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
